/* src/wsfpu_pkg.sv */
// types and constants shared by the websocket frame parser modules
package wsfpu_pkg;

   localparam int unsigned LEN_W = 63;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [1:0] {
      ST_COMPLETE   = 2'd0,
      ST_INCOMPLETE = 2'd1,
      ST_ERROR      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_DRAIN   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       out_byte;
      logic [1:0]       status;
      logic [3:0]       frame_type;
      logic [LEN_W-1:0] payload_length;
      logic [3:0]       payload_offset;
      logic             last;
   } rsp_type;

   // one input byte's worth of results: an optional payload beat then an optional status
   typedef struct packed {
      logic             pay_valid;
      logic [7:0]       pay_byte;
      logic             stat_valid;
      status_type       status;
      logic [3:0]       frame_type;
      logic [LEN_W-1:0] payload_length;
      logic [3:0]       payload_offset;
   } ent_type;

endpackage

/* src/websocket_frame_parse_unmask_unit.sv */
// top level of the masked websocket frame parser and unmasker
//
//   channel   direction  beat payload             handshake
//   req_      in         data_byte, buffer_end    req_valid / req_stall
//   rsp_      out        payload byte or status   rsp_valid / rsp_stall
//
// one input beat per cycle while req_stall is low; the header, length and key bytes are parsed one per beat
// a payload byte is written to the entry queue, then loaded into the output register for rsp_; a byte
// that also ends the frame gives a second beat (its status) after it, through the same output register
// req_stall rises only when the entry queue (QUEUE_DEPTH entries) is full
// synchronous reset returns the parser to the first header byte and empties the queue
module websocket_frame_parse_unmask_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  wsfpu_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wsfpu_pkg::rsp_type rsp_data
);
   import wsfpu_pkg::*;

   logic    fire;
   logic    push;
   ent_type push_data;
   logic    full;
   logic    pop;
   logic    head_valid;
   ent_type head_data;

   assign req_stall = full;
   assign fire      = req_valid && !full;

   wsfpu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data)
   );

   wsfpu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   wsfpu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* src/wsfpu_front.sv */
// front end: header parsing, length and key capture, payload unmasking
module wsfpu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  wsfpu_pkg::req_type req_data,
   output logic              push,
   output wsfpu_pkg::ent_type push_data
);
   import wsfpu_pkg::*;

   localparam logic [7:0] RSV_MASK  = 8'h70;
   localparam logic [6:0] LEN_16    = 7'h7E;
   localparam logic [6:0] LEN_64    = 7'h7F;
   localparam logic [3:0] HDR_BYTES = 4'd2;
   localparam logic [3:0] KEY_END   = 4'd6;

   phase_type        phase_ff, phase_in;
   logic [3:0]       hc_ff, hc_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic [6:0]       short_ff, short_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [31:0]      key_ff, key_in;
   logic [LEN_W-1:0] pc_ff, pc_in;
   logic             early_ff, early_in;

   logic [7:0] b;
   logic [3:0] ext_bytes;
   logic [3:0] hc_inc;
   logic       done_now;
   ent_type    ent;

   function automatic logic opcode_ok(input logic [3:0] op);
      return (op == 4'd0) || (op == 4'd1) || (op == 4'd2) ||
             (op == 4'd8) || (op == 4'd9) || (op == 4'd10);
   endfunction

   always_comb begin
      b        = req_data.data_byte;
      hc_inc   = hc_ff + 4'd1;
      if (short_ff == LEN_16) begin
         ext_bytes = 4'd2;
      end else if (short_ff == LEN_64) begin
         ext_bytes = 4'd8;
      end else begin
         ext_bytes = 4'd0;
      end

      phase_in  = phase_ff;
      hc_in     = hc_ff;
      opcode_in = opcode_ff;
      short_in  = short_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      pc_in     = pc_ff;
      early_in  = early_ff;
      ent       = '0;

      unique case (phase_ff)
         PH_HDR0: begin
            opcode_in = b[3:0];
            early_in  = ((b & RSV_MASK) != 8'd0) || !opcode_ok(b[3:0]);
            hc_in     = 4'd1;
            phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            hc_in    = HDR_BYTES;
            short_in = b[6:0];
            if (early_ff || !b[7]) begin
               ent.stat_valid = 1'b1;
               ent.status     = ST_ERROR;
               phase_in       = PH_DRAIN;
            end else begin
               early_in = 1'b0;
               if (b[6:0] < LEN_16) begin
                  len_in   = LEN_W'(b[6:0]);
                  phase_in = PH_MASK;
               end else begin
                  len_in   = '0;
                  phase_in = PH_EXTLEN;
               end
            end
         end
         PH_EXTLEN: begin
            // top bit of a 64-bit length is only reported once all length bytes are in
            if (hc_ff == HDR_BYTES && short_ff == LEN_64 && b[7]) begin
               early_in = 1'b1;
            end
            len_in = {len_ff[LEN_W-9:0], b};
            hc_in  = hc_inc;
            if (hc_inc == HDR_BYTES + ext_bytes) begin
               if (early_in) begin
                  ent.stat_valid = 1'b1;
                  ent.status     = ST_ERROR;
                  phase_in       = PH_DRAIN;
               end else begin
                  phase_in = PH_MASK;
               end
            end
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], b};
            hc_in  = hc_inc;
            if (hc_inc == KEY_END + ext_bytes) begin
               pc_in = '0;
               if (len_ff == '0) begin
                  ent.stat_valid = 1'b1;
                  ent.status     = ST_COMPLETE;
                  phase_in       = PH_DRAIN;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            ent.pay_valid = 1'b1;
            ent.pay_byte  = b ^ key_ff[{~pc_ff[1:0], 3'b000} +: 8];
            pc_in         = pc_ff + LEN_W'(1);
            if (pc_in == len_ff) begin
               ent.stat_valid = 1'b1;
               ent.status     = ST_COMPLETE;
               phase_in       = PH_DRAIN;
            end
         end
         PH_DRAIN: begin
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase

      if (ent.stat_valid && ent.status == ST_COMPLETE) begin
         ent.frame_type     = opcode_ff;
         ent.payload_length = len_ff;
         ent.payload_offset = KEY_END + ext_bytes;
      end

      done_now = (phase_ff == PH_DRAIN) || ent.stat_valid;
      if (req_data.buffer_end) begin
         if (!done_now) begin
            ent.stat_valid = 1'b1;
            ent.status     = ST_INCOMPLETE;
         end
         phase_in = PH_HDR0;
         hc_in    = '0;
         early_in = 1'b0;
      end

      push      = fire && (ent.pay_valid || ent.stat_valid);
      push_data = ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         hc_ff     <= '0;
         early_ff  <= 1'b0;
         short_ff  <= '0;
         opcode_ff <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         hc_ff     <= hc_in;
         early_ff  <= early_in;
         short_ff  <= short_in;
         opcode_ff <= opcode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         len_ff <= len_in;
         key_ff <= key_in;
         pc_ff  <= pc_in;
      end
   end

endmodule

/* src/wsfpu_queue.sv */
// short queue of parsed entries between the front and back ends
module wsfpu_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wsfpu_pkg::ent_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output wsfpu_pkg::ent_type head_data
);
   import wsfpu_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   ent_type         mem [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;

   always_comb begin
      full       = (count_ff == CW'(DEPTH));
      head_valid = (count_ff != '0);
      head_data  = mem[rd_ff];

      wr_in = wr_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      rd_in = rd_ff;
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule

/* src/wsfpu_back.sv */
// back end: splits each entry into payload and status beats on the output register
module wsfpu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  wsfpu_pkg::ent_type head_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wsfpu_pkg::rsp_type rsp_data
);
   import wsfpu_pkg::*;

   logic    valid_ff, valid_in;
   logic    half_ff, half_in;
   rsp_type data_ff, data_in;
   logic    load;

   always_comb begin
      load     = !valid_ff || !rsp_stall;
      valid_in = valid_ff;
      half_in  = half_ff;
      data_in  = data_ff;
      pop      = 1'b0;

      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            data_in = '0;
            if (head_data.pay_valid && !half_ff) begin
               data_in.kind     = KIND_PAYLOAD;
               data_in.out_byte = head_data.pay_byte;
               // a trailing status keeps the entry at the head for one more beat
               if (head_data.stat_valid) begin
                  half_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               data_in.kind           = KIND_STATUS;
               data_in.status         = head_data.status;
               data_in.frame_type     = head_data.frame_type;
               data_in.payload_length = head_data.payload_length;
               data_in.payload_offset = head_data.payload_offset;
               data_in.last           = 1'b1;
               half_in                = 1'b0;
               pop                    = 1'b1;
            end
         end
      end

      rsp_valid = valid_ff;
      rsp_data  = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* sim/tb_websocket_frame_parse_unmask_unit.sv */
// self-checking testbench for the websocket frame parser: byte buffers in, payload and status beats checked out
`timescale 1ns / 1ps

module tb_websocket_frame_parse_unmask_unit;
   import wsfpu_pkg::*;

   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;
   localparam logic [3:0] OP_RSVD3 = 4'h3;
   localparam logic [3:0] OP_RSVDF = 4'hF;

   localparam logic [6:0] LEN_CODE_16 = 7'h7E;
   localparam logic [6:0] LEN_CODE_64 = 7'h7F;

   localparam int FORM_SHORT = 0;
   localparam int FORM_16    = 1;
   localparam int FORM_64    = 2;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   websocket_frame_parse_unmask_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   req_type buffer_beats[$];
   rsp_type frame_results_due[$];
   int      beats_queued = 0;
   int      mismatches   = 0;
   int      req_wait     = 0;
   int      rsp_hold     = 0;
   logic    calm         = 1'b0;

   // parser shadow state
   phase_type   prs_phase   = PH_HDR0;
   logic [3:0]  prs_hdr_cnt = '0;
   logic [3:0]  prs_opcode  = '0;
   logic [6:0]  prs_len7    = '0;
   logic [63:0] prs_len     = '0;
   logic [31:0] prs_key     = '0;
   logic [62:0] prs_pay_cnt = '0;
   logic        prs_bad     = 1'b0;
   logic        prs_done    = 1'b0;

   function automatic int draw_wait();
      if (calm || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 12);
   endfunction

   function automatic logic opcode_known(input logic [3:0] op);
      return op inside {OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG};
   endfunction

   function automatic logic [3:0] ext_len_bytes();
      if (prs_len7 == LEN_CODE_16) return 4'd2;
      if (prs_len7 == LEN_CODE_64) return 4'd8;
      return 4'd0;
   endfunction

   task automatic clear_parser();
      prs_phase   = PH_HDR0;
      prs_hdr_cnt = '0;
      prs_opcode  = '0;
      prs_len7    = '0;
      prs_len     = '0;
      prs_key     = '0;
      prs_pay_cnt = '0;
      prs_bad     = 1'b0;
      prs_done    = 1'b0;
   endtask

   task automatic close_frame(input status_type st);
      rsp_type r;
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = st;
      if (st == ST_COMPLETE) begin
         r.frame_type     = prs_opcode;
         r.payload_length = prs_len[62:0];
         r.payload_offset = 4'd6 + ext_len_bytes();
      end
      r.last = 1'b1;
      frame_results_due.push_back(r);
      prs_done  = 1'b1;
      prs_phase = PH_DRAIN;
   endtask

   task automatic parse_byte(input req_type beat);
      logic [7:0] b;
      rsp_type    r;
      int         sh;
      b = beat.data_byte;
      case (prs_phase)
         PH_HDR0: begin
            prs_opcode  = b[3:0];
            prs_bad     = (b[6:4] != 3'b000) || !opcode_known(b[3:0]);
            prs_hdr_cnt = 4'd1;
            prs_phase   = PH_HDR1;
         end
         PH_HDR1: begin
            prs_hdr_cnt = 4'd2;
            prs_len7    = b[6:0];
            if (prs_bad || !b[7]) begin
               close_frame(ST_ERROR);
            end else begin
               prs_bad = 1'b0;
               if (b[6:0] < LEN_CODE_16) begin
                  prs_len   = {57'd0, b[6:0]};
                  prs_phase = PH_MASK;
               end else begin
                  prs_len   = '0;
                  prs_phase = PH_EXTLEN;
               end
            end
         end
         PH_EXTLEN: begin
            // a set top bit in the first byte of the 64-bit length is fatal, but only seen late
            if (prs_hdr_cnt == 4'd2 && prs_len7 == LEN_CODE_64 && b[7]) prs_bad = 1'b1;
            prs_len     = {prs_len[55:0], b};
            prs_hdr_cnt = prs_hdr_cnt + 4'd1;
            if (prs_hdr_cnt == 4'd2 + ext_len_bytes()) begin
               if (prs_bad) close_frame(ST_ERROR);
               else prs_phase = PH_MASK;
            end
         end
         PH_MASK: begin
            prs_key     = {prs_key[23:0], b};
            prs_hdr_cnt = prs_hdr_cnt + 4'd1;
            if (prs_hdr_cnt == 4'd6 + ext_len_bytes()) begin
               prs_pay_cnt = '0;
               if (prs_len == 64'd0) close_frame(ST_COMPLETE);
               else prs_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sh         = 8 * (3 - int'(prs_pay_cnt[1:0]));
            r          = '0;
            r.kind     = KIND_PAYLOAD;
            r.out_byte = b ^ prs_key[sh +: 8];
            frame_results_due.push_back(r);
            prs_pay_cnt = prs_pay_cnt + 63'd1;
            if ({1'b0, prs_pay_cnt} == prs_len) close_frame(ST_COMPLETE);
         end
         default: ;
      endcase
      if (beat.buffer_end) begin
         if (!prs_done) close_frame(ST_INCOMPLETE);
         clear_parser();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                  input logic [63:0] want_v);
      $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got_v, want_v);
      mismatches++;
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (frame_results_due.size() == 0) begin
         report_mismatch("beat with nothing due, kind", 64'(got.kind), 64'd0);
      end else begin
         want = frame_results_due.pop_front();
         if (got.kind !== want.kind)
            report_mismatch("kind", 64'(got.kind), 64'(want.kind));
         if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", 64'(got.out_byte), 64'(want.out_byte));
         if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
         if (got.frame_type !== want.frame_type)
            report_mismatch("frame_type", 64'(got.frame_type), 64'(want.frame_type));
         if (got.payload_length !== want.payload_length)
            report_mismatch("payload_length", 64'(got.payload_length),
                            64'(want.payload_length));
         if (got.payload_offset !== want.payload_offset)
            report_mismatch("payload_offset", 64'(got.payload_offset),
                            64'(want.payload_offset));
         if (got.last !== want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
      end
   endtask

   // builds one buffer: header, length, random key, body bytes; cut of 0 keeps it whole
   task automatic queue_buffer(input logic [7:0] b0, input logic masked, input int form,
                               input logic [63:0] len_val, input int body, input int cut);
      logic [7:0] frame_bytes[$];
      int         keep;
      req_type    beat;
      frame_bytes.push_back(b0);
      case (form)
         FORM_16: begin
            frame_bytes.push_back({masked, LEN_CODE_16});
            frame_bytes.push_back(len_val[15:8]);
            frame_bytes.push_back(len_val[7:0]);
         end
         FORM_64: begin
            frame_bytes.push_back({masked, LEN_CODE_64});
            for (int i = 7; i >= 0; i--) frame_bytes.push_back(len_val[8*i +: 8]);
         end
         default: frame_bytes.push_back({masked, len_val[6:0]});
      endcase
      repeat (4 + body) frame_bytes.push_back(8'($urandom));
      keep = (cut <= 0 || cut > frame_bytes.size()) ? frame_bytes.size() : cut;
      for (int i = 0; i < keep; i++) begin
         beat.data_byte  = frame_bytes[i];
         beat.buffer_end = (i == keep - 1);
         buffer_beats.push_back(beat);
         beats_queued++;
      end
   endtask

   function automatic logic [3:0] pick_opcode();
      case ($urandom_range(0, 5))
         0: return OP_CONT;
         1: return OP_TEXT;
         2: return OP_BIN;
         3: return OP_CLOSE;
         4: return OP_PING;
         default: return OP_PONG;
      endcase
   endfunction

   task automatic random_buffer();
      logic [7:0]  b0;
      logic [63:0] lv;
      int          form;
      int          body;
      int          cut;
      if ($urandom_range(0, 4) != 0) begin
         // well-formed frame with random content, now and then cut short or padded
         b0      = 8'($urandom);
         b0[6:4] = 3'b000;
         b0[3:0] = pick_opcode();
         form    = $urandom_range(0, 5);
         if (form <= 3) form = FORM_SHORT;
         else if (form == 4) form = FORM_16;
         else form = FORM_64;
         lv   = 64'($urandom_range(0, (form == FORM_SHORT) ? 20 : 24));
         body = int'(lv) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
         cut  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : 0;
         queue_buffer(b0, 1'b1, form, lv, body, cut);
      end else begin
         queue_buffer(8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 2),
                      {$urandom, $urandom}, $urandom_range(0, 10), $urandom_range(1, 30));
      end
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait  <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            parse_byte(req_data);
            if ($urandom_range(0, 39) == 0) calm <= !calm;
         end
         if (req_wait != 0) begin
            req_valid <= 1'b0;
            req_wait  <= req_wait - 1;
         end else if (buffer_beats.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= buffer_beats.pop_front();
            req_wait  <= draw_wait();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin : rsp_side
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_beat(rsp_data);
            n = draw_wait();
         end else begin
            n = (rsp_hold > 0) ? rsp_hold - 1 : 0;
         end
         rsp_hold  <= n;
         rsp_stall <= (n != 0);
      end
   end

   initial begin
      int guard;
      // single-frame cases, one buffer each
      queue_buffer(8'h81, 1'b1, FORM_SHORT, 64'd0, 0, 0);
      queue_buffer({1'b1, 3'b000, OP_BIN}, 1'b1, FORM_SHORT, 64'd3, 3, 0);
      queue_buffer({1'b0, 3'b000, OP_CONT}, 1'b1, FORM_SHORT, 64'd1, 1, 0);
      queue_buffer({1'b1, 3'b000, OP_CLOSE}, 1'b1, FORM_SHORT, 64'd2, 2, 0);
      queue_buffer({1'b1, 3'b000, OP_PING}, 1'b1, FORM_SHORT, 64'd0, 0, 0);
      queue_buffer({1'b1, 3'b000, OP_PONG}, 1'b1, FORM_SHORT, 64'd1, 1, 0);
      queue_buffer({1'b1, 3'b000, OP_RSVD3}, 1'b1, FORM_SHORT, 64'd1, 1, 0);
      queue_buffer({1'b1, 3'b000, OP_RSVDF}, 1'b1, FORM_SHORT, 64'd0, 0, 0);
      queue_buffer({1'b1, 3'b111, OP_TEXT}, 1'b1, FORM_SHORT, 64'd0, 0, 0);
      // mask bit clear, with bytes after the error
      queue_buffer({1'b1, 3'b000, OP_TEXT}, 1'b0, FORM_SHORT, 64'd2, 2, 0);
      // longest short length, buffer ends in the payload
      queue_buffer({1'b1, 3'b000, OP_TEXT}, 1'b1, FORM_SHORT, 64'd125, 5, 0);
      queue_buffer({1'b1, 3'b000, OP_BIN}, 1'b1, FORM_16, 64'd4, 4, 0);
      queue_buffer({1'b1, 3'b000, OP_BIN}, 1'b1, FORM_16, 64'd0, 0, 0);
      queue_buffer({1'b1, 3'b000, OP_BIN}, 1'b1, FORM_16, 64'hFFFF, 3, 0);
      queue_buffer({1'b1, 3'b000, OP_TEXT}, 1'b1, FORM_64, 64'd2, 2, 0);
      // 64-bit length with its top bit set: error after all eight bytes, else incomplete
      queue_buffer({1'b1, 3'b000, OP_TEXT}, 1'b1, FORM_64, 64'h8000_0000_0000_0001, 1, 0);
      queue_buffer({1'b1, 3'b000, OP_TEXT}, 1'b1, FORM_64, 64'hFFFF_FFFF_FFFF_FFFF, 0, 5);
      queue_buffer({1'b1, 3'b000, OP_TEXT}, 1'b1, FORM_64, 64'h7FFF_FFFF_FFFF_FFFF, 4, 0);
      // buffer of one bad header byte reports incomplete
      queue_buffer(8'hF3, 1'b1, FORM_SHORT, 64'd0, 0, 1);
      queue_buffer(8'h82, 1'b1, FORM_SHORT, 64'd2, 2, 2);
      queue_buffer(8'h82, 1'b1, FORM_SHORT, 64'd2, 2, 4);
      queue_buffer(8'h82, 1'b1, FORM_16, 64'd3, 3, 3);
      queue_buffer(8'h82, 1'b1, FORM_SHORT, 64'd6, 6, 9);
      // trailing bytes after a complete frame
      queue_buffer(8'h81, 1'b1, FORM_SHORT, 64'd2, 5, 0);

      while (beats_queued < 450) random_buffer();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (buffer_beats.size() != 0 || req_valid) @(negedge clock);
      guard = 0;
      while (frame_results_due.size() != 0 && guard < 4000) begin
         @(negedge clock);
         guard++;
      end
      repeat (30) @(negedge clock);
      if (frame_results_due.size() != 0)
         report_mismatch("results still due at the end", 64'(frame_results_due.size()), 64'd0);
      if (mismatches == 0) begin
         $display("websocket_frame_parse_unmask_unit verification clean");
      end else begin
         $display("websocket_frame_parse_unmask_unit verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("websocket_frame_parse_unmask_unit verification failed");
      $finish;
   end

endmodule
